>>> src/i2cms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_pkg
// shared types and codes of the i2c master transaction sequencer
// ----------------------------------------------------------------------------
package i2cms_pkg;

  // function codes of an input word
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_LOAD  = 2'd2;

  // bus command codes of a result word
  localparam logic [3:0] CMD_START    = 4'd0;
  localparam logic [3:0] CMD_ADDR     = 4'd1;
  localparam logic [3:0] CMD_DATA     = 4'd2;
  localparam logic [3:0] CMD_REQUEST  = 4'd3;
  localparam logic [3:0] CMD_ACK      = 4'd4;
  localparam logic [3:0] CMD_NACK     = 4'd5;
  localparam logic [3:0] CMD_RESTART  = 4'd6;
  localparam logic [3:0] CMD_STOP     = 4'd7;
  localparam logic [3:0] CMD_RECOVERY = 4'd8;
  localparam logic [3:0] CMD_COMPLETE = 4'd9;

  // result queue geometry
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = 3;
  localparam int RES_CNT_W = 4;
  localparam int RES_MAX   = 3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0] func;
    logic [6:0] dev_addr;
    logic       dir_read;
    logic       use_reg;
    logic [7:0] reg_addr;
    logic [4:0] length;
    logic [3:0] buf_index;
    logic [7:0] data_byte;
    logic       bus_free;
    logic       ack_seen;
    logic       tx_ready;
    logic       rx_ready;
  } item_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] cmd_byte;
    logic       status_error;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic [3:0] rx_position;
    logic       last;
  } result_t;

endpackage

>>> src/i2cms_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_item_if
// valid/ready channel carrying one input word of the sequencer
// ----------------------------------------------------------------------------
interface i2cms_item_if;
  logic                valid;
  logic                ready;
  i2cms_pkg::item_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/i2cms_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_result_if
// valid/ready channel carrying one bus command word of the sequencer
// ----------------------------------------------------------------------------
interface i2cms_result_if;
  logic                valid;
  logic                ready;
  i2cms_pkg::result_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/i2c_master_transaction_sequencer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_top
// tick driven i2c master sequencer with a queued command output
// ----------------------------------------------------------------------------
// usage
//   item   : input words; func selects poll tick, start transaction or
//            write buffer load. a start is taken only while idle
//   result : bus command words, zero to three per input word, the final one
//            of each word marked by last
//   cfg_we / cfg_wdata : writes timeout_limit, a wait fails once its count
//            of not-ready ticks exceeds it
// timing
//   every input word is handled in the cycle it is accepted; its commands
//   land in an 8 entry result queue and show on result from that register
//   in order, one command per cycle while result.ready is high
//   item accepts one word per cycle while the queue has room for three more
//   commands, so words with no commands (loads, starts, quiet ticks) flow
//   at one per cycle for as long as that room lasts
// reset / stall
//   rst clears the sequencer to idle, timeout_limit to 1000 and empties the
//   queue; the write buffer keeps its contents undefined until loaded
//   a stalled receiver fills the queue, then item.ready drops until it drains
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_top #(
  parameter int BUF_DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  i2cms_item_if.sink              item,
  i2cms_result_if.source          result,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_wdata
);

  // byte counters hold 0..BUF_DEPTH, buffer index holds 0..BUF_DEPTH-1
  localparam int LEN_W = $clog2(BUF_DEPTH + 1);
  localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  // sequencer phases
  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_STARTING     = 4'd1;
  localparam logic [3:0] PH_SELECT       = 4'd2;
  localparam logic [3:0] PH_RESTART      = 4'd3;
  localparam logic [3:0] PH_WAIT_RESTART = 4'd4;
  localparam logic [3:0] PH_WRITE        = 4'd5;
  localparam logic [3:0] PH_WAIT_TX      = 4'd6;
  localparam logic [3:0] PH_READ         = 4'd7;
  localparam logic [3:0] PH_WAIT_RX      = 4'd8;
  localparam logic [3:0] PH_STOP         = 4'd9;

  // control state
  logic [3:0]       phase, phase_next;
  logic [15:0]      wait_count, wait_count_next;
  logic [LEN_W-1:0] byte_pos, byte_pos_next;
  logic [1:0]       fail_streak, fail_streak_next;
  logic             bus_held, bus_held_next;
  logic [6:0]       target_addr, target_addr_next;
  logic             read_dir, read_dir_next;
  logic             reg_mode, reg_mode_next;
  logic [7:0]       reg_byte, reg_byte_next;
  logic [LEN_W-1:0] xfer_len, xfer_len_next;
  logic [15:0]      timeout_limit;

  // write buffer, read port is addressed by byte_pos_next so its output follows byte_pos
  logic [7:0]       wbuf [BUF_DEPTH];
  logic [7:0]       wbuf_rd;
  logic             load_we;
  logic [IDX_W-1:0] load_idx;
  logic [IDX_W-1:0] rd_idx_next;

  // result queue
  i2cms_pkg::result_t     resq [i2cms_pkg::RES_DEPTH];
  logic [i2cms_pkg::RES_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [i2cms_pkg::RES_CNT_W-1:0] count;
  i2cms_pkg::result_t     res [i2cms_pkg::RES_MAX];
  logic [1:0]             n_res;
  logic                   accept;
  logic                   pop;

  // per word helpers
  logic                   do_fail;
  logic                   wait_ready;
  logic [16:0]            wait_inc;
  logic                   timed_out;
  logic [LEN_W-1:0]       pos_inc;
  logic [1:0]             streak_inc;
  logic                   len_ok;

  function automatic i2cms_pkg::result_t mk_res(
    input logic [3:0] cmd,
    input logic [7:0] cmd_byte,
    input logic       err,
    input logic       rv,
    input logic [7:0] rd,
    input logic [3:0] rp
  );
    i2cms_pkg::result_t r;
    r.cmd          = cmd;
    r.cmd_byte     = cmd_byte;
    r.status_error = err;
    r.rx_valid     = rv;
    r.rx_data      = rd;
    r.rx_position  = rp;
    r.last         = 1'b0;
    return r;
  endfunction

  // input side: room for a full burst of commands
  assign item.ready = (count <= i2cms_pkg::RES_CNT_W'(i2cms_pkg::RES_DEPTH - i2cms_pkg::RES_MAX));
  assign accept     = item.valid && item.ready;

  assign result.valid = (count != '0);
  assign result.data  = resq[rd_ptr];
  assign pop          = result.valid && result.ready;

  assign wait_inc   = {1'b0, wait_count} + 17'd1;
  assign timed_out  = wait_inc > {1'b0, timeout_limit};
  assign pos_inc    = byte_pos + LEN_W'(1);
  assign streak_inc = fail_streak + 2'd1;
  assign len_ok     = (item.data.length != 5'd0) &&
                      ({4'd0, item.data.length} <= 9'(BUF_DEPTH));

  assign load_we  = accept && (item.data.func == i2cms_pkg::FUNC_LOAD) &&
                    ({5'd0, item.data.buf_index} < 9'(BUF_DEPTH));
  assign load_idx = IDX_W'(item.data.buf_index);
  assign rd_idx_next = byte_pos_next[IDX_W-1:0];

  always_comb begin
    phase_next       = phase;
    wait_count_next  = wait_count;
    byte_pos_next    = byte_pos;
    fail_streak_next = fail_streak;
    bus_held_next    = bus_held;
    target_addr_next = target_addr;
    read_dir_next    = read_dir;
    reg_mode_next    = reg_mode;
    reg_byte_next    = reg_byte;
    xfer_len_next    = xfer_len;
    do_fail          = 1'b0;
    wait_ready       = 1'b0;
    n_res            = 2'd0;
    for (int i = 0; i < i2cms_pkg::RES_MAX; i++) begin
      res[i] = mk_res(i2cms_pkg::CMD_START, 8'd0, 1'b0, 1'b0, 8'd0, 4'd0);
    end

    if (accept) begin
      unique case (item.data.func)
        i2cms_pkg::FUNC_START: begin
          if (phase == PH_IDLE && len_ok) begin
            target_addr_next = item.data.dev_addr;
            read_dir_next    = item.data.dir_read;
            reg_mode_next    = item.data.use_reg;
            reg_byte_next    = item.data.reg_addr;
            xfer_len_next    = LEN_W'(item.data.length);
            byte_pos_next    = '0;
            wait_count_next  = '0;
            phase_next       = PH_STARTING;
          end
        end
        i2cms_pkg::FUNC_TICK: begin
          // shared ready wait for the restart, tx and rx wait phases
          if (phase == PH_RESTART || phase == PH_WAIT_TX) begin
            wait_ready = item.data.tx_ready;
          end else begin
            wait_ready = item.data.rx_ready;
          end

          unique case (phase)
            PH_STARTING: begin
              if (item.data.bus_free && !bus_held) begin
                bus_held_next = 1'b1;
                res[0] = mk_res(i2cms_pkg::CMD_START, 8'd0, 1'b0, 1'b0, 8'd0, 4'd0);
                res[1] = mk_res(i2cms_pkg::CMD_ADDR,
                                {target_addr, reg_mode ? 1'b0 : read_dir},
                                1'b0, 1'b0, 8'd0, 4'd0);
                n_res      = 2'd2;
                phase_next = PH_SELECT;
              end
            end
            PH_SELECT: begin
              if (!item.data.ack_seen) begin
                do_fail = 1'b1;
              end else begin
                byte_pos_next = '0;
                if (reg_mode) begin
                  res[0] = mk_res(i2cms_pkg::CMD_DATA, reg_byte, 1'b0, 1'b0, 8'd0, 4'd0);
                  n_res      = 2'd1;
                  phase_next = PH_RESTART;
                end else begin
                  phase_next = read_dir ? PH_READ : PH_WRITE;
                end
              end
            end
            PH_WAIT_RESTART: begin
              if (!item.data.ack_seen) begin
                do_fail = 1'b1;
              end else begin
                byte_pos_next = '0;
                phase_next    = PH_READ;
              end
            end
            PH_WRITE: begin
              res[0] = mk_res(i2cms_pkg::CMD_DATA, wbuf_rd, 1'b0, 1'b0, 8'd0, 4'd0);
              n_res      = 2'd1;
              phase_next = PH_WAIT_TX;
            end
            PH_READ: begin
              res[0] = mk_res(i2cms_pkg::CMD_REQUEST, 8'd0, 1'b0, 1'b0, 8'd0, 4'd0);
              n_res      = 2'd1;
              phase_next = PH_WAIT_RX;
            end
            PH_RESTART, PH_WAIT_TX, PH_WAIT_RX: begin
              if (!wait_ready) begin
                if (timed_out) begin
                  do_fail = 1'b1;
                end else begin
                  wait_count_next = wait_inc[15:0];
                end
              end else begin
                wait_count_next = '0;
                if (phase == PH_WAIT_RX) begin
                  byte_pos_next = pos_inc;
                  res[0] = mk_res((pos_inc == xfer_len) ? i2cms_pkg::CMD_NACK
                                                        : i2cms_pkg::CMD_ACK,
                                  8'd0, 1'b0, 1'b1, item.data.data_byte,
                                  4'(byte_pos));
                  n_res      = 2'd1;
                  phase_next = (pos_inc == xfer_len) ? PH_STOP : PH_READ;
                end else if (!item.data.ack_seen) begin
                  do_fail = 1'b1;
                end else if (phase == PH_RESTART) begin
                  res[0] = mk_res(i2cms_pkg::CMD_RESTART, {1'b0, target_addr},
                                  1'b0, 1'b0, 8'd0, 4'd0);
                  n_res         = 2'd1;
                  reg_mode_next = 1'b0;
                  phase_next    = PH_WAIT_RESTART;
                end else begin
                  byte_pos_next = pos_inc;
                  phase_next    = (pos_inc == xfer_len) ? PH_STOP : PH_WRITE;
                end
              end
            end
            PH_STOP: begin
              res[0] = mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b0, 1'b0, 8'd0, 4'd0);
              res[1] = mk_res(i2cms_pkg::CMD_COMPLETE, 8'd0, 1'b0, 1'b0, 8'd0, 4'd0);
              n_res            = 2'd2;
              phase_next       = PH_IDLE;
              fail_streak_next = 2'd0;
              bus_held_next    = 1'b0;
            end
            default: begin
              phase_next = PH_IDLE;
            end
          endcase

          // failure always opens the word: stop, optional recovery, complete
          if (do_fail) begin
            phase_next      = PH_IDLE;
            wait_count_next = '0;
            bus_held_next   = 1'b0;
            res[0] = mk_res(i2cms_pkg::CMD_STOP, 8'd0, 1'b0, 1'b0, 8'd0, 4'd0);
            if (streak_inc == 2'd3) begin
              fail_streak_next = 2'd0;
              res[1] = mk_res(i2cms_pkg::CMD_RECOVERY, {1'b0, target_addr},
                              1'b0, 1'b0, 8'd0, 4'd0);
              res[2] = mk_res(i2cms_pkg::CMD_COMPLETE, 8'd0, 1'b1, 1'b0, 8'd0, 4'd0);
              n_res  = 2'd3;
            end else begin
              fail_streak_next = streak_inc;
              res[1] = mk_res(i2cms_pkg::CMD_COMPLETE, 8'd0, 1'b1, 1'b0, 8'd0, 4'd0);
              n_res  = 2'd2;
            end
          end
        end
        default: begin
        end
      endcase
    end

    // mark the final command of this word
    unique case (n_res)
      2'd1:    res[0].last = 1'b1;
      2'd2:    res[1].last = 1'b1;
      2'd3:    res[2].last = 1'b1;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      wait_count    <= '0;
      byte_pos      <= '0;
      fail_streak   <= '0;
      bus_held      <= 1'b0;
      target_addr   <= '0;
      read_dir      <= 1'b0;
      reg_mode      <= 1'b0;
      reg_byte      <= '0;
      xfer_len      <= '0;
      timeout_limit <= i2cms_pkg::TIMEOUT_RESET;
    end else begin
      phase       <= phase_next;
      wait_count  <= wait_count_next;
      byte_pos    <= byte_pos_next;
      fail_streak <= fail_streak_next;
      bus_held    <= bus_held_next;
      target_addr <= target_addr_next;
      read_dir    <= read_dir_next;
      reg_mode    <= reg_mode_next;
      reg_byte    <= reg_byte_next;
      xfer_len    <= xfer_len_next;
      if (cfg_we) begin
        timeout_limit <= cfg_wdata;
      end
    end
  end

  // write buffer with a registered read that forwards a same-cycle load
  always_ff @(posedge clk) begin
    if (load_we) begin
      wbuf[load_idx] <= item.data.data_byte;
    end
    if (load_we && load_idx == rd_idx_next) begin
      wbuf_rd <= item.data.data_byte;
    end else begin
      wbuf_rd <= wbuf[rd_idx_next];
    end
  end

  // result queue payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < i2cms_pkg::RES_MAX; i++) begin
      if (i < int'(n_res)) begin
        resq[wr_ptr + i2cms_pkg::RES_PTR_W'(i)] <= res[i];
      end
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + i2cms_pkg::RES_PTR_W'(n_res);
      rd_ptr <= rd_ptr + i2cms_pkg::RES_PTR_W'(pop);
      count  <= count + i2cms_pkg::RES_CNT_W'(n_res) - i2cms_pkg::RES_CNT_W'(pop);
    end
  end

  // queue never overflows
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= i2cms_pkg::RES_CNT_W'(i2cms_pkg::RES_DEPTH))
    else $error("result queue overflow");

  // the bus is held only inside a transaction past the start phase
  a_bus_held_phase: assert property (@(posedge clk) disable iff (rst)
    bus_held |-> (phase != PH_IDLE && phase != PH_STARTING))
    else $error("bus held outside a transaction");

  // the failure streak wraps to zero on the third failure
  a_streak_range: assert property (@(posedge clk) disable iff (rst)
    fail_streak != 2'd3)
    else $error("failure streak reached three");

  // byte position never runs past the transfer length
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    byte_pos <= xfer_len)
    else $error("byte position beyond transfer length");

  // a word with commands makes result valid in the following cycle
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    (n_res != 2'd0) |=> result.valid)
    else $error("queued command not presented");

endmodule

>>> dv/i2cms_command_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cms_command_checker
// watches the item and result channels of the i2c master sequencer, predicts
// the bus commands of every accepted word and compares them in order
// ----------------------------------------------------------------------------
module i2cms_command_checker #(
  parameter int BUF_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  i2cms_item_if       item_mon,
  i2cms_result_if     result_mon,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          pending
);
  import i2cms_pkg::*;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_ARMED, SEQ_SELECT, SEQ_REG_SENT, SEQ_RESTARTED,
    SEQ_WRITE, SEQ_TX_WAIT, SEQ_READ, SEQ_RX_WAIT, SEQ_STOP
  } seq_phase_t;

  logic [15:0] timeout_limit;
  seq_phase_t  phase;
  int          wait_count;
  logic [4:0]  byte_pos;
  logic [1:0]  fail_streak;
  logic        bus_held;
  logic [7:0]  write_buffer [BUF_DEPTH];
  logic [6:0]  target_addr;
  logic        read_dir;
  logic        reg_mode;
  logic [7:0]  reg_byte;
  logic [4:0]  xfer_len;

  result_t     cmd_burst [RES_MAX];
  int          burst_len;
  result_t     expected_cmds [$];
  int          error_total = 0;
  int          queued = 0;

  assign mismatches = error_total;
  assign pending    = queued;

  function automatic void reset_model();
    timeout_limit = TIMEOUT_RESET;
    phase         = SEQ_IDLE;
    wait_count    = 0;
    byte_pos      = '0;
    fail_streak   = '0;
    bus_held      = 1'b0;
    target_addr   = '0;
    read_dir      = 1'b0;
    reg_mode      = 1'b0;
    reg_byte      = '0;
    xfer_len      = '0;
    foreach (write_buffer[i]) write_buffer[i] = '0;
  endfunction

  function automatic void put_cmd(logic [3:0] cmd, logic [7:0] cmd_byte, logic err,
                                  logic rxv, logic [7:0] rxd, logic [3:0] rxp);
    result_t r;
    r              = '0;
    r.cmd          = cmd;
    r.cmd_byte     = cmd_byte;
    r.status_error = err;
    r.rx_valid     = rxv;
    r.rx_data      = rxd;
    r.rx_position  = rxp;
    cmd_burst[burst_len] = r;
    burst_len++;
  endfunction

  // stop, recovery on every third failure in a row, then complete with error
  function automatic void abort_transfer();
    put_cmd(CMD_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0);
    phase       = SEQ_IDLE;
    wait_count  = 0;
    fail_streak = fail_streak + 2'd1;
    if (fail_streak == 2'd3) begin
      put_cmd(CMD_RECOVERY, {1'b0, target_addr}, 1'b0, 1'b0, 8'h00, 4'h0);
      fail_streak = '0;
    end
    bus_held = 1'b0;
    put_cmd(CMD_COMPLETE, 8'h00, 1'b1, 1'b0, 8'h00, 4'h0);
  endfunction

  // true while still waiting, including the tick that times out
  function automatic bit still_waiting(logic ready);
    if (!ready) begin
      if (wait_count + 1 > int'(timeout_limit)) abort_transfer();
      else wait_count++;
      return 1'b1;
    end
    wait_count = 0;
    return 1'b0;
  endfunction

  function automatic void advance_sequence(item_t w);
    logic [4:0] pos;
    case (phase)
      SEQ_ARMED: begin
        if (w.bus_free && !bus_held) begin
          bus_held = 1'b1;
          put_cmd(CMD_START, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0);
          put_cmd(CMD_ADDR, {target_addr, reg_mode ? 1'b0 : read_dir},
                  1'b0, 1'b0, 8'h00, 4'h0);
          phase = SEQ_SELECT;
        end
      end
      SEQ_SELECT: begin
        if (!w.ack_seen) abort_transfer();
        else begin
          byte_pos = '0;
          if (reg_mode) begin
            put_cmd(CMD_DATA, reg_byte, 1'b0, 1'b0, 8'h00, 4'h0);
            phase = SEQ_REG_SENT;
          end else begin
            phase = read_dir ? SEQ_READ : SEQ_WRITE;
          end
        end
      end
      SEQ_REG_SENT: begin
        if (!still_waiting(w.tx_ready)) begin
          if (!w.ack_seen) abort_transfer();
          else begin
            put_cmd(CMD_RESTART, {1'b0, target_addr}, 1'b0, 1'b0, 8'h00, 4'h0);
            reg_mode = 1'b0;
            phase    = SEQ_RESTARTED;
          end
        end
      end
      SEQ_RESTARTED: begin
        if (!w.ack_seen) abort_transfer();
        else begin
          byte_pos = '0;
          phase    = SEQ_READ;
        end
      end
      SEQ_WRITE: begin
        put_cmd(CMD_DATA, (byte_pos < BUF_DEPTH) ? write_buffer[byte_pos] : 8'h00,
                1'b0, 1'b0, 8'h00, 4'h0);
        phase = SEQ_TX_WAIT;
      end
      SEQ_TX_WAIT: begin
        if (!still_waiting(w.tx_ready)) begin
          if (!w.ack_seen) abort_transfer();
          else begin
            byte_pos = byte_pos + 5'd1;
            phase    = (byte_pos == xfer_len) ? SEQ_STOP : SEQ_WRITE;
          end
        end
      end
      SEQ_READ: begin
        put_cmd(CMD_REQUEST, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0);
        phase = SEQ_RX_WAIT;
      end
      SEQ_RX_WAIT: begin
        if (!still_waiting(w.rx_ready)) begin
          pos      = byte_pos;
          byte_pos = byte_pos + 5'd1;
          // the final byte is answered with nack
          if (byte_pos == xfer_len) begin
            put_cmd(CMD_NACK, 8'h00, 1'b0, 1'b1, w.data_byte, pos[3:0]);
            phase = SEQ_STOP;
          end else begin
            put_cmd(CMD_ACK, 8'h00, 1'b0, 1'b1, w.data_byte, pos[3:0]);
            phase = SEQ_READ;
          end
        end
      end
      SEQ_STOP: begin
        put_cmd(CMD_STOP, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0);
        phase       = SEQ_IDLE;
        fail_streak = '0;
        bus_held    = 1'b0;
        put_cmd(CMD_COMPLETE, 8'h00, 1'b0, 1'b0, 8'h00, 4'h0);
      end
      default: phase = SEQ_IDLE;
    endcase
  endfunction

  function automatic void predict_word(item_t w);
    burst_len = 0;
    case (w.func)
      FUNC_START: begin
        if (phase == SEQ_IDLE && w.length >= 1 && w.length <= BUF_DEPTH) begin
          target_addr = w.dev_addr;
          read_dir    = w.dir_read;
          reg_mode    = w.use_reg;
          reg_byte    = w.reg_addr;
          xfer_len    = w.length;
          byte_pos    = '0;
          wait_count  = 0;
          phase       = SEQ_ARMED;
        end
      end
      FUNC_LOAD: begin
        if (w.buf_index < BUF_DEPTH) write_buffer[w.buf_index] = w.data_byte;
      end
      FUNC_TICK: advance_sequence(w);
      default: ;
    endcase
    if (burst_len > 0) cmd_burst[burst_len - 1].last = 1'b1;
    for (int i = 0; i < burst_len; i++) expected_cmds.push_back(cmd_burst[i]);
  endfunction

  task automatic report_mismatch(string text);
    $display("%0t ns  mismatch: %s", $time, text);
    error_total++;
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_word(result_t got);
    result_t want;
    if (expected_cmds.size() == 0) begin
      report_mismatch($sformatf("command word %0h with nothing expected", got));
    end else begin
      want = expected_cmds.pop_front();
      compare_field("cmd", 8'(got.cmd), 8'(want.cmd));
      compare_field("cmd_byte", got.cmd_byte, want.cmd_byte);
      compare_field("status_error", 8'(got.status_error), 8'(want.status_error));
      compare_field("rx_valid", 8'(got.rx_valid), 8'(want.rx_valid));
      compare_field("rx_data", got.rx_data, want.rx_data);
      compare_field("rx_position", 8'(got.rx_position), 8'(want.rx_position));
      compare_field("last", 8'(got.last), 8'(want.last));
    end
  endtask

  // outputs first: a word accepted now can only produce commands later
  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      expected_cmds.delete();
    end else begin
      if (result_mon.valid && result_mon.ready) check_word(result_mon.data);
      if (item_mon.valid && item_mon.ready) predict_word(item_mon.data);
      if (cfg_we) timeout_limit = cfg_wdata;
    end
    queued = expected_cmds.size();
  end

endmodule

>>> dv/i2c_master_transaction_sequencer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_top_tb
// drives directed and random transaction traffic into the sequencer with
// random pacing on both channels, at several timeout limits; a checker
// beside the block predicts and compares every command word
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_top_tb;
  import i2cms_pkg::*;

  localparam int BUF_DEPTH = 16;
  // function code the block has no use for
  localparam logic [1:0] FUNC_NONE = 2'd3;
  // words of random traffic, spread over the timeout settings
  localparam int RANDOM_WORDS = 68;
  localparam int SETTINGS_RUN = 4;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  int          mismatches;
  int          pending;
  // random stalls on both channels while set
  bit          jitter_on;

  i2cms_item_if   item_ch ();
  i2cms_result_if result_ch ();

  i2c_master_transaction_sequencer_top #(
    .BUF_DEPTH (BUF_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  i2cms_command_checker #(
    .BUF_DEPTH (BUF_DEPTH)
  ) checker_i (
    .clk        (clk),
    .rst        (rst),
    .item_mon   (item_ch),
    .result_mon (result_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or drops commands
  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  // command receiver: ready held low in random bursts while jitter is on
  initial begin : sink_pacing
    int hold;
    hold = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && jitter_on && $urandom_range(0, 11) == 0)
        hold = $urandom_range(1, 9);
      if (hold > 0) begin
        result_ch.ready <= 1'b0;
        hold--;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // every field random, callers overwrite what they care about
  function automatic item_t scrambled_word();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(item_t)-1:0];
  endfunction

  function automatic item_t tick_word(logic free, logic ack, logic tx, logic rx,
                                      logic [7:0] rx_byte);
    item_t w;
    w           = scrambled_word();
    w.func      = FUNC_TICK;
    w.bus_free  = free;
    w.ack_seen  = ack;
    w.tx_ready  = tx;
    w.rx_ready  = rx;
    w.data_byte = rx_byte;
    return w;
  endfunction

  function automatic item_t start_word(logic [6:0] addr, logic rd, logic use_reg,
                                       logic [7:0] reg_addr, logic [4:0] len);
    item_t w;
    w          = scrambled_word();
    w.func     = FUNC_START;
    w.dev_addr = addr;
    w.dir_read = rd;
    w.use_reg  = use_reg;
    w.reg_addr = reg_addr;
    w.length   = len;
    return w;
  endfunction

  function automatic item_t load_word(logic [3:0] idx, logic [7:0] val);
    item_t w;
    w           = scrambled_word();
    w.func      = FUNC_LOAD;
    w.buf_index = idx;
    w.data_byte = val;
    return w;
  endfunction

  // sluggish transfers see ready far less often, so waits run long
  function automatic logic ready_draw(bit sluggish);
    return sluggish ? ($urandom_range(0, 1) == 0) : ($urandom_range(0, 4) != 0);
  endfunction

  // one word on the item channel, optionally after a random gap,
  // returns at the edge where it is taken; valid stays up for the next word
  task automatic send_word(item_t w);
    @(negedge clk);
    if (jitter_on && $urandom_range(0, 5) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.data  <= w;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  // stop traffic and let every predicted command drain
  task automatic drain_traffic();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    wait (pending == 0);
    // a word with no commands may still be in the block: let it finish
    repeat (4) @(negedge clk);
  endtask

  task automatic write_timeout(logic [15:0] limit);
    cfg_we    <= 1'b1;
    cfg_wdata <= limit;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one transaction with random content, plus some noise mixed into its ticks;
  // the tick budget may run out early, then the next start finds it busy
  task automatic random_transfer(ref int sent, input int budget);
    bit    sluggish;
    int    pick;
    int    len;
    item_t w;
    sluggish = ($urandom_range(0, 3) == 0);
    pick     = $urandom_range(0, 19);
    // mostly short transfers, now and then the whole buffer
    if (pick < 15)      len = $urandom_range(1, 4);
    else if (pick < 19) len = $urandom_range(5, BUF_DEPTH - 1);
    else                len = BUF_DEPTH;
    repeat ($urandom_range(0, 2)) begin
      send_word(load_word(4'($urandom), 8'($urandom)));
      sent++;
    end
    send_word(start_word(7'($urandom), 1'($urandom), $urandom_range(0, 2) == 0,
                         8'($urandom), 5'(len)));
    sent++;
    for (int k = 0; k < 3 * len + 8 && sent < budget; k++) begin
      case ($urandom_range(0, 19))
        0: begin
          // start while busy, or any length at all
          w = start_word(7'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                         5'($urandom));
        end
        1: begin
          w      = scrambled_word();
          w.func = FUNC_NONE;
        end
        2: begin
          w = load_word(4'($urandom), 8'($urandom));
        end
        default: begin
          w = tick_word($urandom_range(0, 7) != 0, $urandom_range(0, 11) != 0,
                        ready_draw(sluggish), ready_draw(sluggish), 8'($urandom));
        end
      endcase
      send_word(w);
      sent++;
    end
  endtask

  initial begin : stimulus
    logic [15:0] limits [SETTINGS_RUN];
    int          sent;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    jitter_on     = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // preload every buffer entry, so no transfer ever sends an unloaded one
    for (int i = 0; i < BUF_DEPTH; i++)
      send_word(load_word(4'(i), (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom)));

    // words the block must ignore: unknown function, lengths out of range
    begin
      item_t w;
      w      = scrambled_word();
      w.func = FUNC_NONE;
      send_word(w);
    end
    send_word(start_word(7'h7F, 1'b1, 1'b1, 8'hFF, 5'd0));
    send_word(start_word(7'h7F, 1'b1, 1'b1, 8'hFF, 5'd17));

    // three nacked selects in a row, the third one adds bus recovery
    send_word(start_word(7'h7F, 1'b0, 1'b0, 8'h00, 5'd1));
    send_word(tick_word(1'b0, 1'b1, 1'b1, 1'b1, 8'h00));  // bus busy, quiet
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));  // start and address
    send_word(tick_word(1'b1, 1'b0, 1'b1, 1'b1, 8'hFF));  // nack
    send_word(start_word(7'h00, 1'b1, 1'b0, 8'h00, 5'd16));
    send_word(tick_word(1'b1, 1'b1, 1'b1, 1'b1, 8'h00));
    send_word(tick_word(1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    send_word(start_word(7'h2A, 1'b1, 1'b1, 8'h00, 5'd2));
    send_word(tick_word(1'b1, 1'b1, 1'b1, 1'b1, 8'h00));
    send_word(tick_word(1'b1, 1'b0, 1'b1, 1'b1, 8'h00));

    // register mode with the write direction still reads, via repeated start
    send_word(start_word(7'h55, 1'b0, 1'b1, 8'hFF, 5'd2));
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));  // start and address
    send_word(start_word(7'h33, 1'b1, 1'b0, 8'h12, 5'd3));  // busy, ignored
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));  // register byte
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));  // tx wait, quiet
    send_word(tick_word(1'b1, 1'b1, 1'b1, 1'b0, 8'h00));  // repeated start
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));  // into read, quiet
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));  // request byte
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));  // rx wait, quiet
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b1, 8'hFF));  // ack first byte
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));  // request byte
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b1, 8'h00));  // nack last byte
    send_word(tick_word(1'b1, 1'b1, 1'b0, 1'b0, 8'h00));  // stop and complete

    // random traffic under several timeout limits, the extremes among them;
    // tight limits make waits time out often
    limits[0] = 16'd1;
    limits[1] = 16'hFFFF;
    limits[2] = 16'd4;
    limits[3] = 16'($urandom_range(2, 12));
    for (int p = 0; p < SETTINGS_RUN; p++) begin
      drain_traffic();
      write_timeout(limits[p]);
      // the last stretch runs with no random stalls
      jitter_on = (p != SETTINGS_RUN - 1);
      sent = 0;
      while (sent < RANDOM_WORDS / SETTINGS_RUN)
        random_transfer(sent, RANDOM_WORDS / SETTINGS_RUN);
    end

    drain_traffic();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/i2cms_pkg.sv
src/i2cms_item_if.sv
src/i2cms_result_if.sv
src/i2c_master_transaction_sequencer_top.sv
dv/i2cms_command_checker.sv
dv/i2c_master_transaction_sequencer_top_tb.sv
